[rtl/dds_pkg.sv]
// Shared constants, types and control structs for the decimal digit sequence adder.
`timescale 1ns / 1ps

package dds_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DIGIT_W    = 4;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W:0]   RADIX     = 5'd10;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_CARRY,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;        // store one accepted input beat
    logic add_step;    // add one digit column, advance column index
    logic carry_step;  // write the leading carry digit, set emit pointer
    logic emit_adv;    // step emit pointer toward the least significant digit
    logic clear;       // drop both operands for the next pair
  } dp_cmd_t;

  typedef struct packed {
    logic pair_done;   // the current beat completes both operands
    logic cols_done;   // every column of the longer operand has been added
    logic emit_last;   // emit pointer is at the least significant digit
  } dp_status_t;

endpackage

[rtl/dds_ctrl.sv]
// Controller state machine: sequences load, column add, carry and emission.
`timescale 1ns / 1ps

module dds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dds_pkg::dp_status_t status,
  output dds_pkg::dp_cmd_t    cmd
);

  dds_pkg::state_t state;
  dds_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dds_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      dds_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.pair_done) begin
            state_next = dds_pkg::ST_ADD_RD;
          end
        end
      end
      dds_pkg::ST_ADD_RD: begin
        if (status.cols_done) begin
          state_next = dds_pkg::ST_CARRY;
        end else begin
          state_next = dds_pkg::ST_ADD_WR;
        end
      end
      dds_pkg::ST_ADD_WR: begin
        cmd.add_step = 1'b1;
        state_next   = dds_pkg::ST_ADD_RD;
      end
      dds_pkg::ST_CARRY: begin
        cmd.carry_step = 1'b1;
        state_next     = dds_pkg::ST_EMIT_RD;
      end
      dds_pkg::ST_EMIT_RD: begin
        state_next = dds_pkg::ST_EMIT;
      end
      dds_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = dds_pkg::ST_LOAD;
          end else begin
            cmd.emit_adv = 1'b1;
            state_next   = dds_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = dds_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

[rtl/dds_datapath.sv]
// Datapath: operand digit stores, column adder with decimal carry, sum store.
`timescale 1ns / 1ps

module dds_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dds_pkg::dp_cmd_t                  cmd,
  input  logic                              req_type,
  input  logic [dds_pkg::DIGIT_W-1:0]       digit,
  input  logic                              last,
  output dds_pkg::dp_status_t               status,
  output logic [dds_pkg::DIGIT_W-1:0]       sum_digit,
  output logic                              last_digit,
  output logic                              overflow
);

  logic [dds_pkg::DIGIT_W-1:0] first_mem  [0:dds_pkg::MAX_DIGITS-1];
  logic [dds_pkg::DIGIT_W-1:0] second_mem [0:dds_pkg::MAX_DIGITS-1];
  logic [dds_pkg::DIGIT_W-1:0] sum_mem    [0:dds_pkg::MAX_DIGITS];

  logic [dds_pkg::CNT_W-1:0]   first_count;
  logic [dds_pkg::CNT_W-1:0]   second_count;
  logic                        first_complete;
  logic                        second_complete;
  logic                        overflow_seen;
  logic [dds_pkg::CNT_W-1:0]   col;
  logic [dds_pkg::CNT_W-1:0]   emit_ptr;
  logic                        carry;

  logic [dds_pkg::DIGIT_W-1:0] first_rd;
  logic [dds_pkg::DIGIT_W-1:0] second_rd;
  logic [dds_pkg::DIGIT_W-1:0] sum_rd;

  logic [dds_pkg::DIGIT_W-1:0] digit_sat;
  logic                        sel_complete;
  logic [dds_pkg::CNT_W-1:0]   sel_count;
  logic                        sel_room;
  logic [dds_pkg::CNT_W-1:0]   len;
  logic [dds_pkg::CNT_W-1:0]   first_idx;
  logic [dds_pkg::CNT_W-1:0]   second_idx;
  logic [dds_pkg::DIGIT_W-1:0] first_term;
  logic [dds_pkg::DIGIT_W-1:0] second_term;
  logic [dds_pkg::DIGIT_W:0]   col_sum;
  logic                        col_carry;
  logic [dds_pkg::DIGIT_W-1:0] col_digit;
  logic [dds_pkg::DIGIT_W:0]   col_wrapped;

  assign digit_sat    = (digit > dds_pkg::DIGIT_MAX) ? dds_pkg::DIGIT_MAX : digit;
  assign sel_complete = req_type ? second_complete : first_complete;
  assign sel_count    = req_type ? second_count : first_count;
  assign sel_room     = sel_count < dds_pkg::CNT_W'(dds_pkg::MAX_DIGITS);

  assign len        = (first_count > second_count) ? first_count : second_count;
  assign first_idx  = first_count - dds_pkg::CNT_W'(1) - col;
  assign second_idx = second_count - dds_pkg::CNT_W'(1) - col;

  // Operand digits are read from the least significant end; short operands pad with zero.
  assign first_term  = (col < first_count) ? first_rd : '0;
  assign second_term = (col < second_count) ? second_rd : '0;
  assign col_sum     = {1'b0, first_term} + {1'b0, second_term} + {4'b0, carry};
  assign col_carry   = col_sum >= dds_pkg::RADIX;
  assign col_wrapped = col_sum - dds_pkg::RADIX;
  assign col_digit   = col_carry ? col_wrapped[dds_pkg::DIGIT_W-1:0]
                                 : col_sum[dds_pkg::DIGIT_W-1:0];

  assign status.pair_done = (first_complete | (~req_type & last)) &
                            (second_complete | (req_type & last));
  assign status.cols_done = col == len;
  assign status.emit_last = emit_ptr == '0;

  assign sum_digit  = sum_rd;
  assign last_digit = emit_ptr == '0;
  assign overflow   = overflow_seen;

  always_ff @(posedge clk) begin
    first_rd  <= first_mem[first_idx[dds_pkg::ADDR_W-1:0]];
    second_rd <= second_mem[second_idx[dds_pkg::ADDR_W-1:0]];
    sum_rd    <= sum_mem[emit_ptr];
    if (cmd.load && !sel_complete && sel_room) begin
      if (req_type) begin
        second_mem[sel_count[dds_pkg::ADDR_W-1:0]] <= digit_sat;
      end else begin
        first_mem[sel_count[dds_pkg::ADDR_W-1:0]] <= digit_sat;
      end
    end
    if (cmd.add_step) begin
      sum_mem[col] <= col_digit;
    end else if (cmd.carry_step && carry) begin
      sum_mem[col] <= dds_pkg::DIGIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      first_count     <= '0;
      second_count    <= '0;
      first_complete  <= 1'b0;
      second_complete <= 1'b0;
      overflow_seen   <= 1'b0;
      col             <= '0;
      carry           <= 1'b0;
      emit_ptr        <= '0;
    end else begin
      if (cmd.load && !sel_complete) begin
        if (sel_room) begin
          if (req_type) begin
            second_count <= second_count + dds_pkg::CNT_W'(1);
          end else begin
            first_count <= first_count + dds_pkg::CNT_W'(1);
          end
        end else begin
          overflow_seen <= 1'b1;
        end
        if (last) begin
          if (req_type) begin
            second_complete <= 1'b1;
          end else begin
            first_complete <= 1'b1;
          end
        end
      end
      if (cmd.add_step) begin
        carry <= col_carry;
        col   <= col + dds_pkg::CNT_W'(1);
      end
      if (cmd.carry_step) begin
        emit_ptr <= carry ? col : col - dds_pkg::CNT_W'(1);
      end
      if (cmd.emit_adv) begin
        emit_ptr <= emit_ptr - dds_pkg::CNT_W'(1);
      end
    end
  end

endmodule

[rtl/decimal_digit_sequence_adder.sv]
// Sequence: digits load one per input beat; once both operands end, each column of the longer
// operand is read, then added and written, the carry is placed, and each sum digit is read
// from the sum store, then offered as an output beat. One operand pair is handled at a time:
// no input beat is taken until the last sum digit of the pair has been taken.
// Reset: synchronous, active high; clears counts, flags and the state machine,
// digit stores hold stale data that is never used.
`timescale 1ns / 1ps

module decimal_digit_sequence_adder (
  input  logic                        clk,
  input  logic                        rst,
  // input channel: one digit of either operand per beat
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [dds_pkg::DIGIT_W-1:0] digit,
  input  logic                        last,
  // output channel: one sum digit per beat, most significant first
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dds_pkg::DIGIT_W-1:0] sum_digit,
  output logic                        last_digit,
  output logic                        overflow
);

  dds_pkg::dp_cmd_t    cmd;
  dds_pkg::dp_status_t status;

  // Controller: accept digits while loading, then walk columns and emit.
  dds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: digit stores, decimal column adder, sum store with registered read,
  // which doubles as the output register that holds a stalled beat.
  dds_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .digit      (digit),
    .last       (last),
    .status     (status),
    .sum_digit  (sum_digit),
    .last_digit (last_digit),
    .overflow   (overflow)
  );

endmodule

[rtl/dds_checker.sv]
// Port-level checker for the decimal digit sequence adder, bound to the top level.
`timescale 1ns / 1ps

module dds_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dds_pkg::DIGIT_W-1:0] sum_digit,
  input logic                        last_digit,
  input logic                        overflow
);

  // A stalled output beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sum_digit) &&
                                $stable(last_digit) && $stable(overflow))
    else $error("stalled output beat changed");

  // Loading and emitting never overlap.
  assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a sum digit is offered");

  // Every emitted digit is decimal.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sum_digit <= dds_pkg::DIGIT_MAX)
    else $error("sum digit above nine");

  // After the final digit the block returns to loading.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_digit |=> !out_valid && in_ready)
    else $error("no return to loading after final sum digit");

endmodule

bind decimal_digit_sequence_adder dds_checker u_dds_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sum_digit  (sum_digit),
  .last_digit (last_digit),
  .overflow   (overflow)
);

[tb/sv/dds_sum_checker.sv]
// Checker for the decimal digit sequence adder: tracks operand loading and scores sum beats.
`timescale 1ns / 1ps

module dds_sum_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        req_type,
  input  logic [dds_pkg::DIGIT_W-1:0] digit,
  input  logic                        last,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [dds_pkg::DIGIT_W-1:0] sum_digit,
  input  logic                        last_digit,
  input  logic                        overflow,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    logic [dds_pkg::DIGIT_W-1:0] value;
    logic                        tail;
    logic                        ovf;
  } sum_beat_t;

  // Operand stores indexed by req_type
  logic [dds_pkg::DIGIT_W-1:0] operand_digits [2][dds_pkg::MAX_DIGITS];
  int                          operand_len    [2];
  logic                        operand_closed [2];
  logic                        truncated;
  sum_beat_t                   sums_due [$];

  function automatic int digit_from_lsb(input int op, input int k);
    if (k < operand_len[op]) return int'(operand_digits[op][operand_len[op] - 1 - k]);
    return 0;
  endfunction

  task automatic clear_operands();
    for (int op = 0; op < 2; op++) begin
      operand_len[op]    = 0;
      operand_closed[op] = 1'b0;
    end
    truncated = 1'b0;
  endtask

  // Add from the least significant column, then queue the sum most significant first.
  task automatic queue_sum();
    int        column [dds_pkg::MAX_DIGITS + 1];
    int        width;
    int        carry;
    int        s;
    sum_beat_t b;
    width = (operand_len[0] > operand_len[1]) ? operand_len[0] : operand_len[1];
    carry = 0;
    for (int k = 0; k < width; k++) begin
      s         = digit_from_lsb(0, k) + digit_from_lsb(1, k) + carry;
      column[k] = s % int'(dds_pkg::RADIX);
      carry     = s / int'(dds_pkg::RADIX);
    end
    if (carry != 0) begin
      column[width] = carry;
      width++;
    end
    for (int k = width - 1; k >= 0; k--) begin
      b.value = dds_pkg::DIGIT_W'(column[k]);
      b.tail  = (k == 0);
      b.ovf   = truncated;
      sums_due.push_back(b);
    end
    clear_operands();
  endtask

  task automatic take_digit(input logic rt, input logic [dds_pkg::DIGIT_W-1:0] d,
                            input logic l);
    logic [dds_pkg::DIGIT_W-1:0] d_sat;
    d_sat = (d > dds_pkg::DIGIT_MAX) ? dds_pkg::DIGIT_MAX : d;
    if (!operand_closed[rt]) begin
      if (operand_len[rt] < dds_pkg::MAX_DIGITS) begin
        operand_digits[rt][operand_len[rt]] = d_sat;
        operand_len[rt]++;
      end else begin
        truncated = 1'b1;
      end
      if (l) operand_closed[rt] = 1'b1;
    end
    if (operand_closed[0] && operand_closed[1]) queue_sum();
  endtask

  task automatic score_beat();
    sum_beat_t want;
    if (sums_due.size() == 0) begin
      $display("%0t: unexpected sum beat digit=%0d last=%0b overflow=%0b",
               $time, sum_digit, last_digit, overflow);
      fail_count++;
    end else begin
      want = sums_due.pop_front();
      if (sum_digit !== want.value) begin
        $display("%0t: sum_digit expected %0d actual %0d", $time, want.value, sum_digit);
        fail_count++;
      end
      if (last_digit !== want.tail) begin
        $display("%0t: last_digit expected %0b actual %0b", $time, want.tail, last_digit);
        fail_count++;
      end
      if (overflow !== want.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, overflow);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_operands();
      sums_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) score_beat();
      if (in_valid && in_ready) take_digit(req_type, digit, last);
    end
    pending = sums_due.size();
  end

endmodule

[tb/sv/tb.sv]
// Top of the decimal digit sequence adder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam logic OPND_FIRST  = 1'b0;
  localparam logic OPND_SECOND = 1'b1;

  localparam int TARGET_ITEMS = 250;
  localparam int LONG_HOLD    = 300;     // receiver stall long enough to back up the input
  localparam int DRAIN_CYCLES = 150;     // covers a full add walk plus a 33-digit emission
  localparam int CYCLE_LIMIT  = 4000000;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic                        req_type;
  logic [dds_pkg::DIGIT_W-1:0] digit;
  logic                        last;
  logic                        out_valid;
  logic                        out_ready;
  logic [dds_pkg::DIGIT_W-1:0] sum_digit;
  logic                        last_digit;
  logic                        overflow;

  int fail_count;
  int pending;
  int out_beats;
  int cycles;
  int items_sent;
  int pair_idx;
  int stall_left;
  int free_left;
  int roll;
  bit long_hold_done;
  bit burst;

  decimal_digit_sequence_adder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .digit      (digit),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sum_digit  (sum_digit),
    .last_digit (last_digit),
    .overflow   (overflow)
  );

  dds_sum_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .digit      (digit),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sum_digit  (sum_digit),
    .last_digit (last_digit),
    .overflow   (overflow),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL decimal_digit_sequence_adder");
      $finish;
    end
  end

  // Count sum beats; the receiver uses this to place its long hold.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) out_beats++;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Operand lengths: mostly short, some long, a few past the store size.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(5, 12);
    if (r < 95) return $urandom_range(13, dds_pkg::MAX_DIGITS);
    return $urandom_range(dds_pkg::MAX_DIGITS + 1, dds_pkg::MAX_DIGITS + 4);
  endfunction

  // Digits above nine show up now and then to exercise saturation.
  function automatic logic [dds_pkg::DIGIT_W-1:0] pick_digit();
    if ($urandom_range(0, 9) == 0) return dds_pkg::DIGIT_W'($urandom_range(10, 15));
    return dds_pkg::DIGIT_W'($urandom_range(0, 9));
  endfunction

  // Receiver: drive out_ready at the falling edge. Hold it low for random stalls,
  // leave it high for occasional free stretches, and once, while the sender waits
  // on a busy block, hold it low long enough that the block stops taking input beats.
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!long_hold_done && out_beats >= 40 && in_valid && !in_ready) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD - 1;
        out_ready     <= 1'b0;
      end else if (free_left > 0) begin
        out_ready <= 1'b1;
        free_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
          stall_left = pick_stall() - 1;
          out_ready <= 1'b0;
        end else begin
          if (roll < 25) free_left = $urandom_range(50, 150);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Offer one input beat, after an optional gap, and hold it until accepted.
  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic offer(input logic rt, input logic [dds_pkg::DIGIT_W-1:0] d, input logic l);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    digit    <= d;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued sum beat has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Load one operand pair with random content. Interleave the two operands or
  // send them back to back, and occasionally slip in a stray beat for an operand
  // that has already closed.
  task automatic add_pair(input int len_a, input int len_b, input bit nines);
    int                          sent [2];
    int                          lens [2];
    logic                        rt;
    logic [dds_pkg::DIGIT_W-1:0] d;
    bit                          serial;
    lens[0] = len_a;
    lens[1] = len_b;
    sent[0] = 0;
    sent[1] = 0;
    serial  = 1'($urandom_range(0, 1));
    while (sent[0] < lens[0] || sent[1] < lens[1]) begin
      if (sent[0] >= lens[0]) rt = OPND_SECOND;
      else if (sent[1] >= lens[1]) rt = OPND_FIRST;
      else if (serial) rt = OPND_FIRST;
      else rt = 1'($urandom_range(0, 1));
      if ((sent[0] >= lens[0]) != (sent[1] >= lens[1]) && $urandom_range(0, 99) < 8)
        offer(~rt, dds_pkg::DIGIT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      d = nines ? dds_pkg::DIGIT_MAX : pick_digit();
      offer(rt, d, sent[rt] == lens[rt] - 1);
      sent[rt]++;
      items_sent++;
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = OPND_FIRST;
    digit      = '0;
    last       = 1'b0;
    out_ready  = 1'b0;
    burst      = 1'b0;
    items_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero plus zero.
    offer(OPND_FIRST, 4'd0, 1'b1);
    offer(OPND_SECOND, 4'd0, 1'b1);
    // Single digits with a carry out.
    offer(OPND_FIRST, 4'd9, 1'b1);
    offer(OPND_SECOND, 4'd9, 1'b1);
    // Digits above nine saturate to nine.
    offer(OPND_FIRST, 4'd15, 1'b1);
    offer(OPND_SECOND, 4'd10, 1'b1);
    // A beat for an operand that already closed is ignored.
    offer(OPND_FIRST, 4'd1, 1'b1);
    offer(OPND_FIRST, 4'd7, 1'b1);
    offer(OPND_SECOND, 4'd2, 1'b1);
    // Interleaved operands with a carry rippling into a new leading digit.
    offer(OPND_FIRST, 4'd1, 1'b0);
    offer(OPND_SECOND, 4'd9, 1'b0);
    offer(OPND_FIRST, 4'd2, 1'b1);
    offer(OPND_SECOND, 4'd9, 1'b1);
    // Leading zeros of the longer operand stay in the sum.
    offer(OPND_FIRST, 4'd0, 1'b0);
    offer(OPND_FIRST, 4'd0, 1'b0);
    offer(OPND_FIRST, 4'd1, 1'b1);
    offer(OPND_SECOND, 4'd5, 1'b1);
    // Second operand closes first, then takes a stray beat; first is longer.
    offer(OPND_SECOND, 4'd4, 1'b1);
    offer(OPND_FIRST, 4'd12, 1'b0);
    offer(OPND_SECOND, 4'd8, 1'b0);
    offer(OPND_FIRST, 4'd3, 1'b1);
    wait_drained();

    // Random pairs. The first few hit the store limits: overflow on each side,
    // and two full stores of nines for the longest sum.
    pair_idx = 0;
    while (items_sent < TARGET_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0);
      case (pair_idx)
        0: add_pair(dds_pkg::MAX_DIGITS + 2, 1, 1'b0);
        1: add_pair(dds_pkg::MAX_DIGITS, dds_pkg::MAX_DIGITS, 1'b1);
        2: add_pair(1, dds_pkg::MAX_DIGITS + 1, 1'b0);
        default: add_pair(pick_len(), pick_len(), $urandom_range(0, 19) == 0);
      endcase
      // Pause the sender until the block has drained, once for sure and then at random.
      if (pair_idx == 6 || $urandom_range(0, 14) == 0) wait_drained();
      pair_idx++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS decimal_digit_sequence_adder");
    end else begin
      $display("FAIL decimal_digit_sequence_adder");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dds_pkg.sv
rtl/dds_ctrl.sv
rtl/dds_datapath.sv
rtl/decimal_digit_sequence_adder.sv
rtl/dds_checker.sv
tb/sv/dds_sum_checker.sv
tb/sv/tb.sv
